>>> rtl/core/vmm_pkg.sv
// Shared types and constants of the vector-times-matrix unit.
`default_nettype none

package vmm_pkg;

  typedef enum logic [1:0] {
    ACT_WR_MAT  = 2'd0,
    ACT_WR_VEC  = 2'd1,
    ACT_COMPUTE = 2'd2
  } action_t;

  localparam int SIZE_W = 5;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic wr_mat;
    logic wr_vec;
    logic rd_en;
    logic first;
    logic last_term;
    logic load_out;
    logic out_last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic acc_ready;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/core/vmm_ctrl.sv
// Controller: load decoding, size register and the compute sequencer.
`default_nettype none

module vmm_ctrl #(
  parameter int MAX_SIZE = 16,
  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  action,
  input  wire logic [3:0]                  row,
  input  wire logic [3:0]                  col,
  input  wire logic                        cfg_write,
  input  wire logic [vmm_pkg::SIZE_W-1:0]  cfg_data,
  input  wire vmm_pkg::status_t            status,
  output vmm_pkg::cmd_t                    cmd,
  output logic [IDX_W-1:0]                 rd_j,
  output logic [IDX_W-1:0]                 rd_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  state_t                     state;
  logic [vmm_pkg::SIZE_W-1:0] size_in_use;
  logic [IDX_W-1:0]           n_m1;
  logic [IDX_W-1:0]           n_m1_next;
  logic                       row_ok;
  logic                       col_ok;
  logic                       take;

  assign in_stall = (state != S_IDLE);
  assign take     = in_valid && (state == S_IDLE);
  assign row_ok   = (32'(row) < MAX_SIZE);
  assign col_ok   = (32'(col) < MAX_SIZE);

  // A size of zero acts as one, and a size above the store acts as the store.
  always_comb begin
    if (size_in_use == '0) begin
      n_m1_next = '0;
    end else if (32'(size_in_use) > MAX_SIZE) begin
      n_m1_next = IDX_W'(MAX_SIZE - 1);
    end else begin
      n_m1_next = IDX_W'(size_in_use - 5'd1);
    end
  end

  always_comb begin
    cmd = '0;
    if (take) begin
      case (action)
        vmm_pkg::ACT_WR_MAT: cmd.wr_mat = row_ok && col_ok;
        vmm_pkg::ACT_WR_VEC: cmd.wr_vec = row_ok;
        default: ;
      endcase
    end
    cmd.rd_en     = (state == S_RUN);
    cmd.first     = (rd_j == '0);
    cmd.last_term = (rd_j == n_m1);
    cmd.load_out  = (state == S_WAIT) && status.acc_ready && status.out_free;
    cmd.out_last  = (rd_i == n_m1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      size_in_use <= vmm_pkg::SIZE_RESET;
      n_m1        <= '0;
      rd_j        <= '0;
      rd_i        <= '0;
    end else begin
      if (cfg_write) begin
        size_in_use <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (take && (action == vmm_pkg::ACT_COMPUTE)) begin
            n_m1  <= n_m1_next;
            rd_j  <= '0;
            rd_i  <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (rd_j == n_m1) begin
            rd_j  <= '0;
            state <= S_WAIT;
          end else begin
            rd_j <= rd_j + 1'b1;
          end
        end
        S_WAIT: begin
          if (cmd.load_out) begin
            if (rd_i == n_m1) begin
              state <= S_IDLE;
            end else begin
              rd_i  <= rd_i + 1'b1;
              state <= S_RUN;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/vmm_datapath.sv
// Datapath: element stores, multiply-accumulate pipeline and output register.
`default_nettype none

module vmm_datapath #(
  parameter int MAX_SIZE  = 16,
  parameter int FRAC_BITS = 16,
  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire vmm_pkg::cmd_t      cmd,
  output vmm_pkg::status_t        status,
  input  wire logic [IDX_W-1:0]   rd_j,
  input  wire logic [IDX_W-1:0]   rd_i,
  input  wire logic [3:0]         row,
  input  wire logic [3:0]         col,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [3:0]              index,
  output logic signed [31:0]      product_value,
  output logic                    saturated,
  output logic                    last
);

  localparam int MEM_DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int ADDR_W    = (MAX_SIZE > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int ACC_W     = 65 + IDX_W;
  localparam logic signed [63:0] RND_BIAS = (64'sd1 <<< FRAC_BITS) - 64'sd1;

  logic signed [31:0] mat_mem [MEM_DEPTH];
  logic signed [31:0] vec_mem [MAX_SIZE];

  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;
  logic [IDX_W-1:0]   vec_wr_addr;

  logic signed [31:0] mat_q;
  logic signed [31:0] vec_q;
  logic               s1_valid, s1_first, s1_last;
  logic signed [63:0] prod;
  logic               s2_valid, s2_first, s2_last;
  logic signed [63:0] term;
  logic               s3_valid, s3_first, s3_last;
  logic signed [ACC_W-1:0] acc;
  logic               acc_ready;

  logic               fits;
  logic signed [31:0] sum_q;

  assign wr_addr     = ADDR_W'(row) * ADDR_W'(MAX_SIZE) + ADDR_W'(col);
  assign rd_addr     = ADDR_W'(rd_j) * ADDR_W'(MAX_SIZE) + ADDR_W'(rd_i);
  assign vec_wr_addr = IDX_W'(row);

  always_ff @(posedge clk) begin
    if (cmd.wr_mat) begin
      mat_mem[wr_addr] <= value;
    end
    if (cmd.rd_en) begin
      mat_q <= mat_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_vec) begin
      vec_mem[vec_wr_addr] <= value;
    end
    if (cmd.rd_en) begin
      vec_q <= vec_mem[rd_j];
    end
  end

  // Tags that travel with each term down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.rd_en;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
    s1_first <= cmd.first;
    s1_last  <= cmd.last_term;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    s3_first <= s2_first;
    s3_last  <= s2_last;
  end

  // Adding the bias before the arithmetic shift truncates negative products
  // toward zero instead of toward minus infinity.
  always_ff @(posedge clk) begin
    prod <= mat_q * vec_q;
    term <= (prod + (prod[63] ? RND_BIAS : 64'sd0)) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (s3_valid) begin
      if (s3_first) begin
        acc <= ACC_W'(term);
      end else begin
        acc <= acc + ACC_W'(term);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_ready <= 1'b0;
    end else if (s3_valid && s3_last) begin
      acc_ready <= 1'b1;
    end else if (cmd.load_out) begin
      acc_ready <= 1'b0;
    end
  end

  // The sum fits when every bit above bit 31 matches the sign bit.
  assign fits  = (acc[ACC_W-1:31] == '0) || (acc[ACC_W-1:31] == '1);
  assign sum_q = fits ? acc[31:0] : (acc[ACC_W-1] ? vmm_pkg::Q_MIN : vmm_pkg::Q_MAX);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      index         <= 4'(rd_i);
      product_value <= sum_q;
      saturated     <= !fits;
      last          <= cmd.out_last;
    end
  end

  assign status.acc_ready = acc_ready;
  assign status.out_free  = !out_valid || !out_stall;

endmodule

`default_nettype wire

>>> rtl/core/vector_matrix_multiply_unit.sv
// Vector-times-matrix unit, signed Q16.16: result[i] = sum over j of vec[j]*M[j][i].
// Load transfers are accepted while the sequencer is idle. A compute transfer reads
// the stores for each result, passes the terms through the multiply-accumulate pipeline
// and loads the output register, holding off input until the last result is loaded; a
// stalled output delays the next load by the stall.
// Reset clears the controller, pipeline valids and output valid and sets the size to 16.
`default_nettype none

module vector_matrix_multiply_unit #(
  parameter int MAX_SIZE  = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [1:0]                 action,
  input  wire logic [3:0]                 row,
  input  wire logic [3:0]                 col,
  input  wire logic signed [31:0]         value,
  input  wire logic                       cfg_write,
  input  wire logic [vmm_pkg::SIZE_W-1:0] cfg_data,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [3:0]                      index,
  output logic signed [31:0]              product_value,
  output logic                            saturated,
  output logic                            last
);

  localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  vmm_pkg::cmd_t    cmd;
  vmm_pkg::status_t status;
  logic [IDX_W-1:0] rd_j;
  logic [IDX_W-1:0] rd_i;

  vmm_ctrl #(
    .MAX_SIZE (MAX_SIZE)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .row       (row),
    .col       (col),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd),
    .rd_j      (rd_j),
    .rd_i      (rd_i)
  );

  vmm_datapath #(
    .MAX_SIZE  (MAX_SIZE),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .rd_j          (rd_j),
    .rd_i          (rd_i),
    .row           (row),
    .col           (col),
    .value         (value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .index         (index),
    .product_value (product_value),
    .saturated     (saturated),
    .last          (last)
  );

`ifndef SYNTHESIS
  // A compute transfer starts the sequencer, which holds off further input.
  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (action == vmm_pkg::ACT_COMPUTE)) |=> in_stall)
    else $error("input not stalled after compute transfer");

  // Store writes happen only on an accepted load transfer.
  a_write_on_transfer: assert property (@(posedge clk) disable iff (rst)
    (cmd.wr_mat || cmd.wr_vec) |-> (in_valid && !in_stall))
    else $error("store write without input transfer");

  // Loading a result always presents it on the output next cycle.
  a_load_presents: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> out_valid)
    else $error("loaded result not presented");

  // Reads and result loads never overlap.
  a_read_vs_load: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rd_en && cmd.load_out))
    else $error("store read during result load");
`endif

endmodule

`default_nettype wire
